// ===== hw/rtl/hmnb_pkg.sv =====
// ----------------------------------------------------------------------------
// hmnb_pkg
// Shared types and constants for the heightmap normalize / box blur block.
// ----------------------------------------------------------------------------
package hmnb_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int AW          = 20;
   localparam int STORE_DEPTH = 2 ** AW;
   localparam int MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_W       = ($clog2(MAX_DIM + 1) > 11) ? $clog2(MAX_DIM + 1) : 11;
   localparam int AREA_W      = 2 * DIM_W;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int HIST_DEPTH  = 2 ** (COL_W + 1);
   localparam int CAP         = (MAX_WIDTH * MAX_HEIGHT > STORE_DEPTH) ?
                                STORE_DEPTH : MAX_WIDTH * MAX_HEIGHT;
   localparam int CNT_W       = $clog2(CAP + 1);
   localparam int BLUR_PASSES = 3;
   localparam int SUM_W       = 20;

   // ceil(2^23 / 9); floor(s * DIV9_RECIP >> DIV9_SHIFT) == s / 9 for s < 2^21
   localparam logic [19:0] DIV9_RECIP = 20'd932068;
   localparam int          DIV9_SHIFT = 23;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_NORM_EN      = 2'd2;
   localparam logic [1:0] CSR_BLUR_EN      = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

// ===== hw/rtl/hmnb_div.sv =====
// ----------------------------------------------------------------------------
// hmnb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hmnb_div
   import hmnb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[31]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/heightmap_normalize_box_blur.sv =====
// ----------------------------------------------------------------------------
// heightmap_normalize_box_blur
// Frame load with min/max tracking, frame reads, in-place normalize and 3x3 mean passes.
// ----------------------------------------------------------------------------
// A read item returns one result item. The load item marked is_last starts
// processing, during which req_stall stays high: normalize reads each pixel
// and, unless the span is zero or the pixel is at or below the minimum, runs a
// 32-step divide in the divider, and each of the three blur passes, when
// enabled, copies rows into the row history and, for each interior pixel,
// makes nine reads and a reciprocal multiply for the divide by 9.
module heightmap_normalize_box_blur
   import hmnb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_pixel_value,
   input  logic        req_is_last,
   input  logic [19:0] req_read_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_height_value,
   output logic        rsp_read_error,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b000000000001,
      ST_RD_WAIT  = 12'b000000000010,
      ST_RD_DONE  = 12'b000000000100,
      ST_NR_RD    = 12'b000000001000,
      ST_NR_CALC  = 12'b000000010000,
      ST_NR_DIV   = 12'b000000100000,
      ST_BL_SETUP = 12'b000001000000,
      ST_CP_RD    = 12'b000010000000,
      ST_CP_WR    = 12'b000100000000,
      ST_AC_RD    = 12'b001000000000,
      ST_AC_ADD   = 12'b010000000000,
      ST_BL_DIV   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [10:0] cfg_width_ff, cfg_height_ff;
   logic        cfg_norm_ff, cfg_blur_ff;

   logic [15:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ready_ff, ready_in;
   logic [AW-1:0]     rd_addr_ff, rd_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_value_ff, rsp_value_in;
   logic              rsp_err_ff, rsp_err_in;
   logic [AREA_W-1:0] i_ff, i_in, base_ff, base_in;
   logic [DIM_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [1:0]        kr_ff, kr_in, kc_ff, kc_in, pass_ff, pass_in;
   logic              cur_ff, cur_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic [15:0] frame_mem [STORE_DEPTH];
   logic [15:0] hist_mem [HIST_DEPTH];
   logic [15:0] fm_rdata_ff, hm_rdata_ff;
   logic          fm_we, hm_we;
   logic [AW-1:0] fm_waddr, fm_raddr;
   logic [15:0]   fm_wdata;
   logic [COL_W:0] hm_waddr, hm_raddr;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic              accept;
   logic [DIM_W-1:0]  w_eff, h_eff, col;
   logic [AREA_W-1:0] area, n_eff;
   logic [CNT_W-1:0]  cnt_base;
   logic [15:0]       lo_base, hi_base, span, diff, clamped;
   logic [39:0]       mean_prod;
   logic [15:0]       mean;

   hmnb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign w_eff = (cfg_width_ff > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(cfg_width_ff);
   assign h_eff = (cfg_height_ff > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(cfg_height_ff);
   assign area  = AREA_W'(w_eff) * AREA_W'(h_eff);
   assign n_eff = (area > STORE_DEPTH) ? AREA_W'(STORE_DEPTH) : area;
   assign span  = (hi_ff > lo_ff) ? 16'(hi_ff - lo_ff) : 16'd0;
   assign diff  = 16'(fm_rdata_ff - lo_ff);
   assign clamped = (div_rsp.quotient > 32'd65535) ? 16'hFFFF : div_rsp.quotient[15:0];
   assign col   = DIM_W'(x_ff + DIM_W'(kc_ff) - DIM_W'(1));

   // divide by 9 as a reciprocal multiply
   assign mean_prod = 40'(sum_ff) * 40'(DIV9_RECIP);
   assign mean      = mean_prod[DIV9_SHIFT+15:DIV9_SHIFT];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign cnt_base  = ready_ff ? '0 : cnt_ff;
   assign lo_base   = ready_ff ? 16'hFFFF : lo_ff;
   assign hi_base   = ready_ff ? 16'h0000 : hi_ff;

   // frame memory read address
   always_comb begin
      case (state_ff)
         ST_NR_RD: fm_raddr = i_ff[AW-1:0];
         ST_CP_RD: fm_raddr = AW'(base_ff + AREA_W'(x_ff));
         ST_AC_RD: fm_raddr = AW'(base_ff + AREA_W'(w_eff) + AREA_W'(col));
         default:  fm_raddr = rd_addr_ff;
      endcase
   end

   // kr selects the row: 0 previous, 1 current, 2 the row below in the frame
   assign hm_raddr = {(kr_ff == 2'd0) ? ~cur_ff : cur_ff, col[COL_W-1:0]};
   assign hm_waddr = {cur_ff, x_ff[COL_W-1:0]};
   assign hm_we    = (state_ff == ST_CP_WR);

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cnt_in       = cnt_ff;
      ready_in     = ready_ff;
      rd_addr_in   = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      i_in         = i_ff;
      base_in      = base_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      pass_in      = pass_ff;
      cur_in       = cur_ff;
      sum_in       = sum_ff;
      fm_we        = 1'b0;
      fm_waddr     = i_ff[AW-1:0];
      fm_wdata     = 16'd0;
      div_req      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_READ) begin
               rd_addr_in = req_read_address;
               state_in   = ST_RD_WAIT;
            end else if (accept) begin
               ready_in = 1'b0;
               lo_in    = lo_base;
               hi_in    = hi_base;
               cnt_in   = cnt_base;
               if (cnt_base < CAP) begin
                  fm_we    = 1'b1;
                  fm_waddr = AW'(cnt_base);
                  fm_wdata = req_pixel_value;
                  if (req_pixel_value < lo_base) lo_in = req_pixel_value;
                  if (req_pixel_value > hi_base) hi_in = req_pixel_value;
                  cnt_in = cnt_base + CNT_W'(1);
               end
               if (req_is_last) begin
                  i_in    = '0;
                  pass_in = '0;
                  if (cfg_norm_ff && n_eff != '0) state_in = ST_NR_RD;
                  else                              state_in = ST_BL_SETUP;
               end
            end
         end
         ST_RD_WAIT: state_in = ST_RD_DONE;
         ST_RD_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (!ready_ff || AREA_W'(rd_addr_ff) >= area) begin
                  rsp_value_in = 16'd0;
                  rsp_err_in   = 1'b1;
               end else begin
                  rsp_value_in = fm_rdata_ff;
                  rsp_err_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_NR_RD: state_in = ST_NR_CALC;
         ST_NR_CALC: begin
            if (span == 16'd0 || fm_rdata_ff <= lo_ff) begin
               fm_we = 1'b1;
               if (i_ff + AREA_W'(1) == n_eff) state_in = ST_BL_SETUP;
               else begin
                  i_in     = i_ff + AREA_W'(1);
                  state_in = ST_NR_RD;
               end
            end else begin
               // (p - min) * 65535 as (d << 16) - d
               div_req.start    = 1'b1;
               div_req.dividend = {diff, 16'd0} - {16'd0, diff};
               div_req.divisor  = span;
               state_in         = ST_NR_DIV;
            end
         end
         ST_NR_DIV: begin
            if (div_rsp.done) begin
               fm_we    = 1'b1;
               fm_wdata = clamped;
               if (i_ff + AREA_W'(1) == n_eff) state_in = ST_BL_SETUP;
               else begin
                  i_in     = i_ff + AREA_W'(1);
                  state_in = ST_NR_RD;
               end
            end
         end
         ST_BL_SETUP: begin
            if (!cfg_blur_ff || pass_ff == 2'(BLUR_PASSES) ||
                w_eff < DIM_W'(3) || h_eff < DIM_W'(3)) begin
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               x_in     = '0;
               y_in     = '0;
               base_in  = '0;
               cur_in   = 1'b0;
               state_in = ST_CP_RD;
            end
         end
         ST_CP_RD: state_in = ST_CP_WR;
         ST_CP_WR: begin
            if (x_ff == w_eff - DIM_W'(1)) begin
               if (y_ff == '0) begin
                  cur_in   = ~cur_ff;
                  y_in     = DIM_W'(1);
                  base_in  = base_ff + AREA_W'(w_eff);
                  x_in     = '0;
                  state_in = ST_CP_RD;
               end else begin
                  x_in     = DIM_W'(1);
                  kr_in    = '0;
                  kc_in    = '0;
                  sum_in   = '0;
                  state_in = ST_AC_RD;
               end
            end else begin
               x_in     = x_ff + DIM_W'(1);
               state_in = ST_CP_RD;
            end
         end
         ST_AC_RD: state_in = ST_AC_ADD;
         ST_AC_ADD: begin
            sum_in = sum_ff + SUM_W'((kr_ff == 2'd2) ? fm_rdata_ff : hm_rdata_ff);
            if (kc_ff == 2'd2) begin
               kc_in = '0;
               kr_in = kr_ff + 2'd1;
            end else begin
               kc_in = kc_ff + 2'd1;
            end
            if (kc_ff == 2'd2 && kr_ff == 2'd2) begin
               state_in = ST_BL_DIV;
            end else begin
               state_in = ST_AC_RD;
            end
         end
         ST_BL_DIV: begin
            fm_we    = 1'b1;
            fm_waddr = AW'(base_ff + AREA_W'(x_ff));
            fm_wdata = mean;
            if (x_ff == w_eff - DIM_W'(2)) begin
               cur_in  = ~cur_ff;
               y_in    = y_ff + DIM_W'(1);
               base_in = base_ff + AREA_W'(w_eff);
               x_in    = '0;
               if (y_ff == h_eff - DIM_W'(2)) begin
                  pass_in  = pass_ff + 2'd1;
                  state_in = ST_BL_SETUP;
               end else begin
                  state_in = ST_CP_RD;
               end
            end else begin
               x_in     = x_ff + DIM_W'(1);
               kr_in    = '0;
               kc_in    = '0;
               sum_in   = '0;
               state_in = ST_AC_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_width_ff  <= 11'd1024;
         cfg_height_ff <= 11'd1024;
         cfg_norm_ff   <= 1'b1;
         cfg_blur_ff   <= 1'b0;
         lo_ff         <= 16'hFFFF;
         hi_ff         <= 16'h0000;
         cnt_ff        <= '0;
         ready_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         cnt_ff       <= cnt_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  cfg_width_ff  <= csr_data;
               CSR_FRAME_HEIGHT: cfg_height_ff <= csr_data;
               CSR_NORM_EN:      cfg_norm_ff   <= csr_data[0];
               CSR_BLUR_EN:      cfg_blur_ff   <= csr_data[0];
               default:          cfg_blur_ff   <= cfg_blur_ff;
            endcase
         end
      end
      rd_addr_ff   <= rd_addr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      i_ff         <= i_in;
      base_ff      <= base_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      kr_ff        <= kr_in;
      kc_ff        <= kc_in;
      pass_ff      <= pass_in;
      cur_ff       <= cur_in;
      sum_ff       <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (fm_we) begin
         frame_mem[fm_waddr] <= fm_wdata;
      end
      fm_rdata_ff <= frame_mem[fm_raddr];
   end

   always_ff @(posedge clock) begin
      if (hm_we) begin
         hist_mem[hm_waddr] <= fm_rdata_ff;
      end
      hm_rdata_ff <= hist_mem[hm_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_height_value = rsp_value_ff;
   assign rsp_read_error   = rsp_err_ff;

endmodule
